// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the binary xnor popcount threshold block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low asynchronous reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the default clock and reset names of this project.
`define ASSERT_RST(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/bxpt_pkg.sv =====
// Package of the binary xnor popcount threshold block: constants, queue types and
// the word popcount function. No dependencies.
package bxpt_pkg;

  localparam int WORD_BITS           = 32;
  localparam int WORD_SHIFT          = $clog2(WORD_BITS);
  localparam int LANES               = 4;
  localparam int STEPS               = 2;
  localparam int THR_W               = 16;
  localparam int CFG_W               = 13;
  localparam int PC_W                = $clog2(WORD_BITS + 1);
  localparam int OUT_BITS_W          = 4;
  localparam int IN_W                = STEPS * WORD_BITS + LANES * WORD_BITS + LANES * THR_W;
  localparam int OUT_W               = STEPS * OUT_BITS_W;
  localparam int MAX_KERNEL_BITS_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam logic [CFG_W-1:0] KERNEL_BITS_RST = CFG_W'(32);

  // One classified word set, waiting for the accumulator.
  typedef struct packed {
    logic                                   last;
    logic [LANES-1:0][STEPS-1:0][PC_W-1:0]  pcnt;
    logic [LANES-1:0][THR_W-1:0]            thr;
  } bxpt_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bxpt_qstat_t;

  // Population count of one word as a five-level adder tree.
  function automatic logic [PC_W-1:0] popcount32(input logic [WORD_BITS-1:0] w);
    logic [15:0][1:0] l1;
    logic [7:0][2:0]  l2;
    logic [3:0][3:0]  l3;
    logic [1:0][4:0]  l4;
    for (int i = 0; i < 16; i++) begin
      l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

// ===== rtl/core/bxpt_front.sv =====
// Front end: holds the kernel length register and the word index, masks the last
// word and computes the eight popcounts. Depends on bxpt_pkg.
module bxpt_front #(
  parameter int MAX_KERNEL_BITS = bxpt_pkg::MAX_KERNEL_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bxpt_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bxpt_pkg::IN_W-1:0]   s_axis_tdata,
  input  bxpt_pkg::bxpt_qstat_t       q_stat_i,
  output logic                        q_push_o,
  output bxpt_pkg::bxpt_entry_t       q_entry_o
);
  import bxpt_pkg::*;

  localparam int WordsMax = (MAX_KERNEL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int IdxW     = (WordsMax > 1) ? $clog2(WordsMax) : 1;
  localparam int WordsW   = CFG_W + 1 - WORD_SHIFT;

  logic [CFG_W-1:0]      kernel_bits_q, kernel_bits_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [CFG_W-1:0]      kb_sat;
  logic [CFG_W:0]        kb_round;
  logic [WordsW-1:0]     words;
  logic [WORD_SHIFT-1:0] rem;
  logic                  last;
  logic [WORD_BITS-1:0]  mask;
  logic [STEPS-1:0][WORD_BITS-1:0] act;
  logic [LANES-1:0][WORD_BITS-1:0] wgt;

  assign s_axis_tready = !q_stat_i.full;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (32'(kernel_bits_q) > 32'(MAX_KERNEL_BITS)) begin
      kb_sat = CFG_W'(MAX_KERNEL_BITS);
    end else begin
      kb_sat = kernel_bits_q;
    end
    kb_round = {1'b0, kb_sat} + (CFG_W + 1)'(WORD_BITS - 1);
    words    = kb_round[CFG_W:WORD_SHIFT];
    rem      = kb_sat[WORD_SHIFT-1:0];
    // A zero length behaves as a single full word.
    last     = (words == '0) || ((32'(idx_q) + 32'd1) >= 32'(words));
    if (last && (rem != '0)) begin
      mask = ~({WORD_BITS{1'b1}} >> rem);
    end else begin
      mask = {WORD_BITS{1'b1}};
    end
  end

  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      act[s] = s_axis_tdata[s*WORD_BITS +: WORD_BITS];
    end
    for (int l = 0; l < LANES; l++) begin
      wgt[l] = s_axis_tdata[(STEPS + l)*WORD_BITS +: WORD_BITS];
    end
    q_entry_o.last = last;
    for (int l = 0; l < LANES; l++) begin
      q_entry_o.thr[l] = s_axis_tdata[(STEPS + LANES)*WORD_BITS + l*THR_W +: THR_W];
      for (int s = 0; s < STEPS; s++) begin
        q_entry_o.pcnt[l][s] = popcount32(~(act[s] ^ wgt[l]) & mask);
      end
    end
  end

  always_comb begin
    kernel_bits_d = cfg_we_i ? cfg_wdata_i : kernel_bits_q;
    idx_d         = idx_q;
    if (q_push_o) begin
      idx_d = last ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_bits_q <= KERNEL_BITS_RST;
      idx_q         <= '0;
    end else begin
      kernel_bits_q <= kernel_bits_d;
      idx_q         <= idx_d;
    end
  end

endmodule

// ===== rtl/core/bxpt_fifo.sv =====
// Short queue of classified word sets between the front end and the accumulator.
// Depends on bxpt_pkg.
module bxpt_fifo #(
  parameter int Depth = bxpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  bxpt_pkg::bxpt_entry_t  wdata_i,
  input  logic                   pop_i,
  output bxpt_pkg::bxpt_entry_t  rdata_o,
  output bxpt_pkg::bxpt_qstat_t  stat_o
);
  import bxpt_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bxpt_entry_t           mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/bxpt_back.sv =====
// Back end: accumulates the match sums, thresholds them on the last word and
// holds the result register. Depends on bxpt_pkg.
module bxpt_back #(
  parameter int MAX_KERNEL_BITS = bxpt_pkg::MAX_KERNEL_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bxpt_pkg::bxpt_qstat_t       q_stat_i,
  input  bxpt_pkg::bxpt_entry_t       q_entry_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bxpt_pkg::OUT_W-1:0]  m_axis_tdata
);
  import bxpt_pkg::*;

  localparam int WordsMax = (MAX_KERNEL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int SumW     = $clog2(WordsMax * WORD_BITS + 1);
  localparam int CmpW     = ((SumW > THR_W) ? SumW : THR_W) + 1;

  logic [LANES-1:0][STEPS-1:0][SumW-1:0] sums_q, sums_d, sum_new;
  logic [STEPS-1:0][OUT_BITS_W-1:0]      bits;
  logic                                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]                      out_data_q;

  // A word that ends no kernel never needs the result register.
  assign q_pop_o = !q_stat_i.empty && (!q_entry_i.last || !out_valid_q || m_axis_tready);

  always_comb begin
    bits = '0;
    for (int l = 0; l < LANES; l++) begin
      for (int s = 0; s < STEPS; s++) begin
        sum_new[l][s] = sums_q[l][s] + SumW'(q_entry_i.pcnt[l][s]);
        bits[s][OUT_BITS_W-1-l] =
          $signed({1'b0, CmpW'(sum_new[l][s])}) >=
          $signed({{(CmpW + 1 - THR_W){q_entry_i.thr[l][THR_W-1]}}, q_entry_i.thr[l]});
      end
    end
  end

  always_comb begin
    sums_d      = sums_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (q_pop_o) begin
      sums_d = q_entry_i.last ? '0 : sum_new;
      if (q_entry_i.last) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sums_q      <= sums_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_entry_i.last) begin
      out_data_q <= bits;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/binary_xnor_popcount_threshold.sv =====
// Binary xnor popcount threshold core: four output channels over two time steps.
// Throughput is one word set per cycle unless the queue is full or a result waits; the
// popcount front end and the accumulator each handle one request per clock and the queue decouples them.
// A last word goes through the queue and the accumulator into the result register.
// Reset: kernel_bits returns to 32, match sums and word index clear, queue empties.
// Depends on bxpt_pkg, bxpt_front, bxpt_fifo, bxpt_back and assert_macros.svh.
`include "assert_macros.svh"

module binary_xnor_popcount_threshold #(
  parameter int MAX_KERNEL_BITS = bxpt_pkg::MAX_KERNEL_BITS_DEF,
  parameter int QUEUE_DEPTH     = bxpt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Kernel length register: written whenever the write enable is high.
  input  logic                        cfg_we_i,
  input  logic [bxpt_pkg::CFG_W-1:0]  cfg_wdata_i,
  // Input request, from bit 0 up: act_word_first, act_word_second,
  // weight_lane0..3 (32 bits each), thresh_lane0..3 (16 bits each, signed).
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bxpt_pkg::IN_W-1:0]   s_axis_tdata,
  // Result request, from bit 0 up: bits_first_step, bits_second_step (4 bits each).
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bxpt_pkg::OUT_W-1:0]  m_axis_tdata
);
  import bxpt_pkg::*;

  // The front end accepts a request whenever the queue has room. It decides
  // whether the word ends the kernel, masks the unused low bits of a partial
  // last word and reduces the eight xnor words to popcounts, so the queue
  // entry is narrow.
  logic        q_push;
  logic        q_pop;
  bxpt_entry_t q_wdata;
  bxpt_entry_t q_entry;
  bxpt_qstat_t q_stat;

  bxpt_front #(
    .MAX_KERNEL_BITS(MAX_KERNEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_entry_o     (q_wdata)
  );

  bxpt_fifo #(
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_entry),
    .stat_o  (q_stat)
  );

  // The back end adds popcounts into the running sums. A word that ends a
  // kernel waits only for the result register to be free; other words drain
  // even while a result is stalled.
  bxpt_back #(
    .MAX_KERNEL_BITS(MAX_KERNEL_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `ASSERT_RST(a_queue_state, !(q_stat.full && q_stat.empty), "queue full and empty at once")
  `ASSERT_RST(a_pop_nonempty, q_pop |-> !q_stat.empty, "accumulator popped an empty queue")
  `ASSERT_RST(a_last_gives_result, q_pop && q_entry.last |=> m_axis_tvalid, "kernel end lost its result")

endmodule

// ===== verif/bxpt_checker.sv =====
`timescale 1ns / 1ps
// Checker of the binary xnor popcount threshold block: follows the kernel length register,
// predicts the decision bits of every finished kernel and compares them with the results.
// Depends on bxpt_pkg only.
module bxpt_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bxpt_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [bxpt_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [bxpt_pkg::OUT_W-1:0]  m_axis_tdata,
  output int                          fail_count_o,
  output int                          pending_o
);
  import bxpt_pkg::*;

  typedef struct packed {
    logic [OUT_BITS_W-1:0] first_step;
    logic [OUT_BITS_W-1:0] second_step;
  } decision_t;

  decision_t        expected_decisions[$];
  logic [CFG_W-1:0] kernel_bits_q;
  int               match_sum [LANES][STEPS];
  int               words_taken;
  int               errors = 0;

  function automatic int count_agreeing(input logic [WORD_BITS-1:0] act,
                                        input logic [WORD_BITS-1:0] wgt,
                                        input logic [WORD_BITS-1:0] mask);
    logic [WORD_BITS-1:0] agree;
    int                   n;
    agree = ~(act ^ wgt) & mask;
    n = 0;
    for (int b = 0; b < WORD_BITS; b++) begin
      n += agree[b];
    end
    return n;
  endfunction

  // Adds one word set into the sums; on the last word of a kernel it queues the decisions.
  task automatic accumulate_word(input logic [IN_W-1:0] req);
    int                      kb;
    int                      words;
    int                      rem;
    logic [WORD_BITS-1:0]    mask;
    logic [WORD_BITS-1:0]    act [STEPS];
    logic [WORD_BITS-1:0]    wgt;
    logic signed [THR_W-1:0] thr;
    bit                      last;
    decision_t               dec;
    kb = int'(kernel_bits_q);
    if (kb > MAX_KERNEL_BITS_DEF) kb = MAX_KERNEL_BITS_DEF;
    words = (kb + WORD_BITS - 1) / WORD_BITS;
    if (words == 0) words = 1;
    rem  = kb % WORD_BITS;
    last = (words_taken + 1) >= words;
    mask = '1;
    if (last && rem != 0) mask = ~((32'd1 << (WORD_BITS - rem)) - 32'd1);
    for (int ts = 0; ts < STEPS; ts++) begin
      act[ts] = req[ts*WORD_BITS +: WORD_BITS];
    end
    for (int lane = 0; lane < LANES; lane++) begin
      wgt = req[(STEPS+lane)*WORD_BITS +: WORD_BITS];
      for (int ts = 0; ts < STEPS; ts++) begin
        match_sum[lane][ts] += count_agreeing(act[ts], wgt, mask);
      end
    end
    if (!last) begin
      words_taken++;
      return;
    end
    dec = '0;
    for (int lane = 0; lane < LANES; lane++) begin
      thr = req[(STEPS+LANES)*WORD_BITS + lane*THR_W +: THR_W];
      for (int ts = 0; ts < STEPS; ts++) begin
        if (match_sum[lane][ts] >= int'(thr)) begin
          if (ts == 0) dec.first_step[LANES-1-lane] = 1'b1;
          else dec.second_step[LANES-1-lane] = 1'b1;
        end
        match_sum[lane][ts] = 0;
      end
    end
    words_taken = 0;
    expected_decisions.push_back(dec);
  endtask

  task automatic compare_decision(input logic [OUT_W-1:0] data);
    decision_t             exp_dec;
    logic [OUT_BITS_W-1:0] got_first;
    logic [OUT_BITS_W-1:0] got_second;
    got_first  = data[0 +: OUT_BITS_W];
    got_second = data[OUT_BITS_W +: OUT_BITS_W];
    if (expected_decisions.size() == 0) begin
      errors++;
      $display("%0t: result expected none actual %h", $time, data);
      return;
    end
    exp_dec = expected_decisions.pop_front();
    if (exp_dec.first_step !== got_first) begin
      errors++;
      $display("%0t: bits_first_step expected %h actual %h", $time, exp_dec.first_step,
               got_first);
    end
    if (exp_dec.second_step !== got_second) begin
      errors++;
      $display("%0t: bits_second_step expected %h actual %h", $time, exp_dec.second_step,
               got_second);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_bits_q = KERNEL_BITS_RST;
      for (int lane = 0; lane < LANES; lane++) begin
        for (int ts = 0; ts < STEPS; ts++) begin
          match_sum[lane][ts] = 0;
        end
      end
      words_taken = 0;
      expected_decisions.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (s_axis_tvalid && s_axis_tready) accumulate_word(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_decision(m_axis_tdata);
      if (cfg_we_i) kernel_bits_q = cfg_wdata_i;
      pending_o    <= expected_decisions.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== verif/binary_xnor_popcount_threshold_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the binary xnor popcount threshold block: drives the kernel length
// register and both stream sides, and reports the verdict. Depends on bxpt_pkg,
// bxpt_checker and the RTL of the block.
module binary_xnor_popcount_threshold_test;
  import bxpt_pkg::*;

  // The run is far shorter than this; the limit only catches a hung block.
  localparam int RUN_LIMIT     = 400000;
  localparam int RANDOM_ITEMS  = 950;
  localparam int HOLD_CYCLES   = 80;
  // Cycles that let word sets without a result leave the pipeline before a register write.
  localparam int SETTLE_CYCLES = 10;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tready = 1'b0;
  wire               s_axis_tready;
  wire               m_axis_tvalid;
  wire  [OUT_W-1:0]  m_axis_tdata;

  int fail_count;
  int pending;
  int burst_left  = 0;
  int hold_token  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int ready_mode  = 0;
  int mode_left   = 0;
  int sent_random = 0;
  int span_bits   = 32;
  int cycles      = 0;

  binary_xnor_popcount_threshold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bxpt_checker decision_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver side. A hold request from the stimulus keeps tready low for a long stretch,
  // counted here, so that the block fills up and pushes back on its input. Otherwise the
  // receiver switches between always ready, half, mostly ready and mostly stalled.
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(5, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Packs one request, first field in the lowest bits.
  function automatic logic [IN_W-1:0] pack_request(
    input logic [WORD_BITS-1:0] act0, input logic [WORD_BITS-1:0] act1,
    input logic [WORD_BITS-1:0] w0,   input logic [WORD_BITS-1:0] w1,
    input logic [WORD_BITS-1:0] w2,   input logic [WORD_BITS-1:0] w3,
    input logic [THR_W-1:0]     t0,   input logic [THR_W-1:0]     t1,
    input logic [THR_W-1:0]     t2,   input logic [THR_W-1:0]     t3);
    return {t3, t2, t1, t0, w3, w2, w1, w0, act1, act0};
  endfunction

  // Offers one request and returns at the edge that accepts it. The sender works in bursts;
  // between bursts it may pause, and sometimes runs on without a gap.
  task automatic offer_request(input logic [IN_W-1:0] req);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops the sender and waits until every predicted result has been seen, then lets the
  // pipeline empty of word sets that cause no result.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the kernel length while the block is idle. The sums and word index of a
  // kernel in progress stay, which is how a length change in mid-kernel is reached.
  task automatic write_kernel_bits(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (value == 0) span_bits = WORD_BITS;
    else if (value > MAX_KERNEL_BITS_DEF) span_bits = MAX_KERNEL_BITS_DEF;
    else span_bits = int'(value);
  endtask

  // Thresholds mostly fall inside the reachable sum range so that both decisions occur,
  // with some near zero and some anywhere in the signed range.
  function automatic logic [THR_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return THR_W'($urandom_range(0, span_bits + 1));
    if (r < 80) return THR_W'(int'($urandom_range(0, 4)) - 2);
    return THR_W'($urandom_range(0, 65535));
  endfunction

  // Random word set. Activations often copy a weight word with one bit flipped, or its
  // inverse, so that the sums reach both ends of their range.
  task automatic offer_random_word();
    logic [WORD_BITS-1:0] wgt [LANES];
    logic [WORD_BITS-1:0] act [STEPS];
    int                   r;
    for (int lane = 0; lane < LANES; lane++) begin
      r = $urandom_range(0, 9);
      if (r == 0) wgt[lane] = '0;
      else if (r == 1) wgt[lane] = '1;
      else wgt[lane] = $urandom;
    end
    for (int ts = 0; ts < STEPS; ts++) begin
      r = $urandom_range(0, 9);
      if (r < 4) act[ts] = wgt[$urandom_range(0, LANES-1)] ^ (32'd1 << $urandom_range(0, 31));
      else if (r == 4) act[ts] = ~wgt[$urandom_range(0, LANES-1)];
      else act[ts] = $urandom;
    end
    offer_request(pack_request(act[0], act[1], wgt[0], wgt[1], wgt[2], wgt[3],
                               pick_threshold(), pick_threshold(),
                               pick_threshold(), pick_threshold()));
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] kb, input int count);
    write_kernel_bits(kb);
    repeat (count) offer_random_word();
    sent_random += count;
  endtask

  // Kernel lengths are mostly short: zero, one word, one bit more or less than a word,
  // whole multiples of a word and odd lengths, so that results come often.
  function automatic logic [CFG_W-1:0] pick_kernel_bits();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return CFG_W'(WORD_BITS);
    if (r < 24) return ($urandom_range(0, 1) == 0) ? CFG_W'(WORD_BITS - 1) : CFG_W'(WORD_BITS + 1);
    if (r < 34) return CFG_W'(WORD_BITS * $urandom_range(1, 4));
    if (r < 40) return CFG_W'(WORD_BITS * $urandom_range(1, 4) + WORD_BITS - 1);
    return CFG_W'($urandom_range(1, 160));
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length of one full word. Sums of 32 and of 0 meet thresholds at, just above
    // and just below them, and the most negative and most positive thresholds.
    offer_request(pack_request('0, '0, '0, '0, '0, '0,
                               16'd32, 16'd33, 16'd0, 16'h8000));
    offer_request(pack_request('1, '1, '0, '0, '0, '0,
                               16'd0, 16'd1, 16'h7FFF, 16'hFFFF));
    offer_request(pack_request('1, '0, '1, '0, 32'hAAAAAAAA, 32'h55555555,
                               16'd16, 16'd16, 16'd16, 16'd17));
    offer_request(pack_request(32'h80000001, 32'h7FFFFFFE, 32'h80000000, 32'h00000001,
                               '1, '0, 16'd31, 16'd30, 16'd2, 16'd1));

    // One-bit kernel: only the top bit of each word counts.
    write_kernel_bits(CFG_W'(1));
    offer_request(pack_request(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                               '1, '0, 16'd1, 16'd1, 16'd1, 16'd1));
    offer_request(pack_request(32'h7FFFFFFF, 32'h80000000, '0, '1, 32'h80000000, '0,
                               16'd0, 16'd2, 16'hFFFF, 16'd1));

    // Zero length behaves as one full word.
    write_kernel_bits('0);
    offer_request(pack_request('0, 32'h0000FFFF, '0, '1, 32'hFFFF0000, 32'h0000FFFF,
                               16'd32, 16'd32, 16'd16, 16'd17));

    // One bit short of a word: the lowest bit is dropped.
    write_kernel_bits(CFG_W'(WORD_BITS - 1));
    offer_request(pack_request(32'hFFFFFFFE, 32'h00000001, '1, '0, '1, '0,
                               16'd31, 16'd31, 16'd32, 16'd30));

    // One bit past a word: a full word, then a last word with only its top bit.
    write_kernel_bits(CFG_W'(WORD_BITS + 1));
    offer_request(pack_request('1, '0, '1, '1, '0, 32'h12345678,
                               16'd0, 16'd0, 16'd0, 16'd0));
    offer_request(pack_request(32'h80000000, 32'h7FFFFFFF, '1, '0, 32'h80000000, 32'h0,
                               16'd33, 16'd32, 16'd1, 16'd2));

    // Length cut in mid-kernel: five-word kernel left after three words, then a two-word
    // length, so the next word ends the kernel at once; then one regular two-word kernel.
    write_kernel_bits(CFG_W'(5 * WORD_BITS));
    offer_request(pack_request('1, '0, '1, '0, '1, '0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_request(pack_request('1, '0, '1, '0, '1, '0, 16'd0, 16'd0, 16'd0, 16'd0));
    offer_request(pack_request('1, '0, '1, '0, '1, '0, 16'd0, 16'd0, 16'd0, 16'd0));
    write_kernel_bits(CFG_W'(2 * WORD_BITS));
    offer_request(pack_request('1, '0, '1, '0, '1, '0,
                               16'd128, 16'd96, 16'd129, 16'd32));
    offer_request(pack_request(32'hF0F0F0F0, 32'h0F0F0F0F, '1, '0, 32'hF0F0F0F0, '1,
                               16'd0, 16'd0, 16'd0, 16'd0));
    offer_request(pack_request(32'hF0F0F0F0, 32'h0F0F0F0F, '1, '0, 32'hF0F0F0F0, '1,
                               16'd32, 16'd33, 16'd64, 16'd31));

    // Back pressure: the receiver holds off while the sender keeps offering one-word
    // kernels, so the result path fills up and the input stalls.
    write_kernel_bits(CFG_W'(WORD_BITS));
    hold_token <= hold_token + 1;
    repeat (24) offer_random_word();
    sent_random += 24;

    // The longest kernel, written once directly and once as the largest register value,
    // which saturates to the same length.
    run_random_phase(CFG_W'(MAX_KERNEL_BITS_DEF), MAX_KERNEL_BITS_DEF / WORD_BITS);
    run_random_phase('1, MAX_KERNEL_BITS_DEF / WORD_BITS);

    // Random phases end at arbitrary word counts, so many of them cut a kernel short.
    while (sent_random < RANDOM_ITEMS) begin
      run_random_phase(pick_kernel_bits(), $urandom_range(8, 48));
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bxpt_pkg.sv
rtl/core/bxpt_front.sv
rtl/core/bxpt_fifo.sv
rtl/core/bxpt_back.sv
rtl/core/binary_xnor_popcount_threshold.sv
verif/bxpt_checker.sv
verif/binary_xnor_popcount_threshold_test.sv
